FILE: rtl/core/dsh4enc_pkg.sv
`default_nettype none

package dsh4enc_pkg;

    localparam int MOTORS        = 4;
    localparam int THR_W         = 16;
    localparam int DUTY_W        = 16;
    localparam int SLOT_W        = 6;
    localparam int VALUE_W       = 11;
    localparam int PACKET_W      = 16;
    localparam int PRODUCT_W     = 27;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam int FRAME_SLOTS_DEFAULT = 20;
    localparam int FRAME_SLOTS_MIN     = 17;
    localparam int FRAME_SLOTS_MAX     = 64;

    localparam logic [THR_W-1:0]     STOP_LIMIT    = 16'd65;
    localparam logic [VALUE_W-1:0]   MIN_THROTTLE  = 11'd48;
    localparam logic [PRODUCT_W-1:0] THROTTLE_SPAN = 27'd1999;

    localparam logic [DUTY_W-1:0]    BIT_PERIOD_RESET = 16'd560;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TELEMETRY  = 2'd1;

    typedef logic [MOTORS-1:0][THR_W-1:0]    throttle_vec_t;
    typedef logic [MOTORS-1:0][PRODUCT_W-1:0] product_vec_t;
    typedef logic [MOTORS-1:0][VALUE_W-1:0]  value_vec_t;
    typedef logic [MOTORS-1:0][PACKET_W-1:0] packet_vec_t;

    // Build the 16-bit packet: value, telemetry bit, nibble XOR checksum
    function automatic logic [PACKET_W-1:0] make_packet(
        input logic [VALUE_W-1:0] value,
        input logic               telem
    );
        logic [11:0] payload;
        logic [3:0]  csum;
        payload = {value, telem};
        csum    = payload[3:0] ^ payload[7:4] ^ payload[11:8];
        return {payload, csum};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dsh4enc_if.sv
`default_nettype none

interface dsh4enc_cmd_if;
    import dsh4enc_pkg::*;
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] throttle_a;
    logic [THR_W-1:0] throttle_b;
    logic [THR_W-1:0] throttle_c;
    logic [THR_W-1:0] throttle_d;

    modport source (output valid, throttle_a, throttle_b, throttle_c, throttle_d,
                    input ready);
    modport sink   (input valid, throttle_a, throttle_b, throttle_c, throttle_d,
                    output ready);
endinterface

interface dsh4enc_slot_if;
    import dsh4enc_pkg::*;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic [DUTY_W-1:0] duty_d;
    logic [SLOT_W-1:0] slot_index;
    logic              last_slot;

    modport source (output valid, duty_a, duty_b, duty_c, duty_d, slot_index, last_slot,
                    input ready);
    modport sink   (input valid, duty_a, duty_b, duty_c, duty_d, slot_index, last_slot,
                    output ready);
endinterface

interface dsh4enc_cfg_if;
    import dsh4enc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dshot_four_channel_encoder_unit.sv
`default_nettype none

// DShot four-channel frame encoder.
// cmd  : one transaction carries four Q0.16 throttle fractions, one per motor.
// slot : one transaction per bit slot of the frame, four timer compare values,
//        the slot number and a last-slot mark. FRAME_SLOTS (limited to 17..64)
//        per command: 16 data slots MSB first, then all-zero reset slots.
// cfg  : register writes (0 bit period in ticks, 1 telemetry bit); always ready.
//        Write only while no frame is pending.
// The first slot of a command is presented once it has passed the multiply
// stage, then scale, pack, frame load and the output register.
// Throughput: one slot per cycle while the receiver is ready; the
// slot emitter, which walks the stored packets one slot per cycle, sets this.
// Three further commands can wait in the pipeline while a frame is sent.
// Reset clears all valid flags and the slot counter and restores the register
// defaults (560 ticks, telemetry off).
// When the receiver stalls, the slot output holds; the emitter and the
// pipeline behind it stop, and cmd.ready drops once all stages are full.
module dshot_four_channel_encoder_unit #(
    parameter int FRAME_SLOTS = dsh4enc_pkg::FRAME_SLOTS_DEFAULT
) (
    input  wire               clk,
    input  wire               rst_n,
    dsh4enc_cmd_if.sink       cmd,
    dsh4enc_cfg_if.sink       cfg,
    dsh4enc_slot_if.source    slot
);
    import dsh4enc_pkg::*;

    localparam int SLOTS = (FRAME_SLOTS < FRAME_SLOTS_MIN) ? FRAME_SLOTS_MIN :
                           (FRAME_SLOTS > FRAME_SLOTS_MAX) ? FRAME_SLOTS_MAX : FRAME_SLOTS;
    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W-1:0] PACKET_BITS = SLOT_W'(PACKET_W);

    // Configuration registers
    logic [DUTY_W-1:0] bit_period_reg;
    logic              telemetry_reg;

    // Pipeline stages
    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    product_vec_t  s1_product_reg;
    logic [MOTORS-1:0] s1_stop_reg;
    value_vec_t    s2_value_reg;
    packet_vec_t   s3_packet_reg;
    logic          s1_load, s2_load, s3_load;

    // Frame emitter
    logic              frame_active_reg;
    logic [SLOT_W-1:0] slot_reg;
    packet_vec_t       packet_store_reg;
    logic              out_load, pkt_take, at_last;

    // Output register
    logic                            out_valid_reg;
    logic [MOTORS-1:0][DUTY_W-1:0]   out_duty_reg;
    logic [SLOT_W-1:0]               out_slot_reg;
    logic                            out_last_reg;

    // Combinational helpers
    throttle_vec_t                   thr_in;
    product_vec_t                    product_next;
    logic [MOTORS-1:0]               stop_next;
    value_vec_t                      value_next;
    packet_vec_t                     packet_next;
    logic [MOTORS-1:0][DUTY_W-1:0]   duty_next;
    logic [DUTY_W+2:0]               one_wide, zero_wide;
    logic [DUTY_W-1:0]               one_ticks, zero_ticks;
    logic [PRODUCT_W:0]              scaled [MOTORS];
    logic [11:0]                     quot [MOTORS];

    // Take register writes; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RESET;
            telemetry_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BIT_PERIOD: bit_period_reg <= cfg.data;
                CFG_TELEMETRY:  telemetry_reg  <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Stage handshake: a stage loads when empty or when it empties this cycle
    assign at_last  = (slot_reg == LAST_SLOT);
    assign out_load = frame_active_reg && (!out_valid_reg || slot.ready);
    assign pkt_take = s3_valid_reg && (!frame_active_reg || (out_load && at_last));
    assign s3_load  = !s3_valid_reg || pkt_take;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign cmd.ready = s1_load;

    assign thr_in = {cmd.throttle_d, cmd.throttle_c, cmd.throttle_b, cmd.throttle_a};

    // Stage 1 logic: scale each fraction by the throttle span
    always_comb
    begin
        for (int m = 0; m < MOTORS; m++)
        begin
            product_next[m] = PRODUCT_W'(thr_in[m]) * THROTTLE_SPAN;
            stop_next[m]    = (thr_in[m] <= STOP_LIMIT);
        end
    end

    // Stage 2 logic: divide by 65535 as (x + (x >> 16) + 1) >> 16
    always_comb
    begin
        for (int m = 0; m < MOTORS; m++)
        begin
            scaled[m] = {1'b0, s1_product_reg[m]}
                      + (PRODUCT_W+1)'(s1_product_reg[m] >> 16) + (PRODUCT_W+1)'(1);
            quot[m]   = scaled[m][PRODUCT_W:16];
            value_next[m] = s1_stop_reg[m] ? '0 : (MIN_THROTTLE + quot[m][VALUE_W-1:0]);
        end
    end

    // Stage 3 logic: pack value, telemetry bit and checksum
    always_comb
    begin
        for (int m = 0; m < MOTORS; m++)
        begin
            packet_next[m] = make_packet(s2_value_reg[m], telemetry_reg);
        end
    end

    // Advance the three pipeline stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load) s1_valid_reg <= cmd.valid;
            if (s2_load) s2_valid_reg <= s1_valid_reg;
            if (s3_load) s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && cmd.valid)
        begin
            s1_product_reg <= product_next;
            s1_stop_reg    <= stop_next;
        end
        if (s2_load && s1_valid_reg) s2_value_reg  <= value_next;
        if (s3_load && s2_valid_reg) s3_packet_reg <= packet_next;
    end

    // Compare values for a one and a zero bit
    assign one_wide   = (DUTY_W+3)'(bit_period_reg) * (DUTY_W+3)'(6);
    assign zero_wide  = (DUTY_W+3)'(bit_period_reg) * (DUTY_W+3)'(3);
    assign one_ticks  = one_wide[DUTY_W+2:3];
    assign zero_ticks = zero_wide[DUTY_W+2:3];

    // Select this slot's compare value for each motor, MSB first
    always_comb
    begin
        for (int m = 0; m < MOTORS; m++)
        begin
            if (slot_reg < PACKET_BITS)
                duty_next[m] = packet_store_reg[m][~slot_reg[3:0]] ? one_ticks : zero_ticks;
            else
                duty_next[m] = '0;
        end
    end

    // Walk the frame slot by slot; load the next frame on its last slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_active_reg <= 1'b0;
            slot_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (pkt_take)
            begin
                frame_active_reg <= 1'b1;
                slot_reg         <= '0;
            end
            else if (out_load)
            begin
                if (at_last)
                begin
                    frame_active_reg <= 1'b0;
                    slot_reg         <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + SLOT_W'(1);
                end
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (slot.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_take) packet_store_reg <= s3_packet_reg;
        if (out_load)
        begin
            out_duty_reg <= duty_next;
            out_slot_reg <= slot_reg;
            out_last_reg <= at_last;
        end
    end

    assign slot.valid      = out_valid_reg;
    assign slot.duty_a     = out_duty_reg[0];
    assign slot.duty_b     = out_duty_reg[1];
    assign slot.duty_c     = out_duty_reg[2];
    assign slot.duty_d     = out_duty_reg[3];
    assign slot.slot_index = out_slot_reg;
    assign slot.last_slot  = out_last_reg;

`ifndef SYNTHESIS
    a_ready_only_when_stage_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && frame_active_reg))
        else $error("command stalled with a free stage");

    a_slot_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (slot.valid && slot.ready && !slot.last_slot) |=>
        (!slot.valid || (slot.slot_index == ($past(slot.slot_index) + SLOT_W'(1)))))
        else $error("slot index skipped or repeated");

    a_last_slot_index: assert property (@(posedge clk) disable iff (!rst_n)
        (slot.valid && slot.last_slot) |-> (slot.slot_index == LAST_SLOT))
        else $error("last slot mark on wrong slot");

    a_idle_counter_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_active_reg |-> (slot_reg == '0))
        else $error("slot counter not cleared between frames");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;

    import dsh4enc_pkg::*;

    localparam int FRAME_LEN   = FRAME_SLOTS_DEFAULT;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_CAP   = 40;
    localparam int PHASE_ITEMS = 55;

    // Register indexes the block does not decode; writes to them are ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [THR_W-1:0] a;
        logic [THR_W-1:0] b;
        logic [THR_W-1:0] c;
        logic [THR_W-1:0] d;
    } throttle_cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        logic [DUTY_W-1:0] duty_d;
        logic [SLOT_W-1:0] slot_no;
        logic              last;
    } slot_result_t;

    logic clk;
    logic rst_n;

    dsh4enc_cmd_if  cmd_bus ();
    dsh4enc_cfg_if  cfg_bus ();
    dsh4enc_slot_if slot_bus ();

    dshot_four_channel_encoder_unit #(
        .FRAME_SLOTS (FRAME_LEN)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .cfg   (cfg_bus),
        .slot  (slot_bus)
    );

    // Shadow copy of the block's registers
    logic [CFG_DATA_W-1:0] bit_period_cfg = BIT_PERIOD_RESET;
    logic                  telemetry_cfg  = 1'b0;

    throttle_cmd_t cmds_to_send [$];
    slot_result_t  slots_due [$];
    throttle_cmd_t next_cmd;
    slot_result_t  due_slot;

    int  cmds_issued   = 0;
    int  cmds_accepted = 0;
    int  cfg_writes    = 0;
    int  mismatches    = 0;
    int  hold_requests = 0;
    int  holds_served  = 0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;
    bit  steady        = 1'b0;
    logic cmd_fired;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("mismatch %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    // Throttle fraction to 16-bit packet: value, telemetry bit, nibble checksum
    function automatic logic [PACKET_W-1:0] motor_packet(input logic [THR_W-1:0] frac,
                                                         input logic telem);
        logic [31:0] level;
        logic [11:0] payload;
        logic [3:0]  sum;
        if (frac <= STOP_LIMIT)
            level = 32'd0;
        else
            level = 32'(MIN_THROTTLE) + (32'(frac) * 32'(THROTTLE_SPAN)) / 32'hFFFF;
        payload = {level[VALUE_W-1:0], telem};
        sum     = payload[3:0] ^ payload[7:4] ^ payload[11:8];
        return {payload, sum};
    endfunction

    // Expand one command into the slots of its frame
    task automatic encode_frame(input throttle_cmd_t c);
        logic [THR_W-1:0]    frac [MOTORS];
        logic [PACKET_W-1:0] pkt [MOTORS];
        logic [DUTY_W-1:0]   duty [MOTORS];
        logic [31:0]         one_ticks;
        logic [31:0]         zero_ticks;
        int                  slots;
        slot_result_t        r;
        frac = '{c.a, c.b, c.c, c.d};
        for (int m = 0; m < MOTORS; m++)
            pkt[m] = motor_packet(frac[m], telemetry_cfg);
        one_ticks  = (32'(bit_period_cfg) * 32'd6) / 32'd8;
        zero_ticks = (32'(bit_period_cfg) * 32'd3) / 32'd8;
        slots = FRAME_LEN;
        if (slots < FRAME_SLOTS_MIN)
            slots = FRAME_SLOTS_MIN;
        if (slots > FRAME_SLOTS_MAX)
            slots = FRAME_SLOTS_MAX;
        for (int s = 0; s < slots; s++)
        begin
            for (int m = 0; m < MOTORS; m++)
            begin
                if (s < PACKET_W)
                    duty[m] = pkt[m][PACKET_W-1-s] ? one_ticks[DUTY_W-1:0]
                                                   : zero_ticks[DUTY_W-1:0];
                else
                    duty[m] = '0;
            end
            r.duty_a  = duty[0];
            r.duty_b  = duty[1];
            r.duty_c  = duty[2];
            r.duty_d  = duty[3];
            r.slot_no = SLOT_W'(s);
            r.last    = (s == slots - 1);
            slots_due.push_back(r);
        end
    endtask

    // Command driver: hold until taken, then offer the next pending command, with random gaps unless steady
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_bus.valid <= 1'b0;
        else if (cmd_bus.valid && !cmd_fired)
        begin
            // hold the current transaction
        end
        else if (cmds_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 20))
        begin
            next_cmd = cmds_to_send.pop_front();
            cmd_bus.valid      <= 1'b1;
            cmd_bus.throttle_a <= next_cmd.a;
            cmd_bus.throttle_b <= next_cmd.b;
            cmd_bus.throttle_c <= next_cmd.c;
            cmd_bus.throttle_d <= next_cmd.d;
        end
        else
            cmd_bus.valid <= 1'b0;
    end

    // Slot receiver: random back-pressure, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            hold_left    = HOLD_CYCLES;
            holds_served = holds_served + 1;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            slot_bus.ready <= 1'b0;
        end
        else
            slot_bus.ready <= steady || ($urandom_range(0, 99) >= 20);
    end

    // Monitor: track register writes, predict frames, check slots
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_fired <= 1'b0;
        else
        begin
            cmd_fired <= cmd_bus.valid && cmd_bus.ready;
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.index)
                    CFG_BIT_PERIOD: bit_period_cfg = cfg_bus.data;
                    CFG_TELEMETRY:  telemetry_cfg  = cfg_bus.data[0];
                    default:        ;
                endcase
                cfg_writes <= cfg_writes + 1;
            end
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                encode_frame('{cmd_bus.throttle_a, cmd_bus.throttle_b,
                               cmd_bus.throttle_c, cmd_bus.throttle_d});
                cmds_accepted <= cmds_accepted + 1;
            end
            if (slot_bus.valid && slot_bus.ready)
            begin
                if (slots_due.size() == 0)
                    report_mismatch("slot with nothing due, slot_index",
                                    32'(slot_bus.slot_index), 32'd0);
                else
                begin
                    due_slot = slots_due.pop_front();
                    if (slot_bus.duty_a !== due_slot.duty_a)
                        report_mismatch("duty_a", 32'(slot_bus.duty_a), 32'(due_slot.duty_a));
                    if (slot_bus.duty_b !== due_slot.duty_b)
                        report_mismatch("duty_b", 32'(slot_bus.duty_b), 32'(due_slot.duty_b));
                    if (slot_bus.duty_c !== due_slot.duty_c)
                        report_mismatch("duty_c", 32'(slot_bus.duty_c), 32'(due_slot.duty_c));
                    if (slot_bus.duty_d !== due_slot.duty_d)
                        report_mismatch("duty_d", 32'(slot_bus.duty_d), 32'(due_slot.duty_d));
                    if (slot_bus.slot_index !== due_slot.slot_no)
                        report_mismatch("slot_index", 32'(slot_bus.slot_index),
                                        32'(due_slot.slot_no));
                    if (slot_bus.last_slot !== due_slot.last)
                        report_mismatch("last_slot", 32'(slot_bus.last_slot),
                                        32'(due_slot.last));
                end
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if ((cmd_bus.valid && cmd_bus.ready) || (slot_bus.valid && slot_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        int seen;
        seen = cfg_writes;
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        while (cfg_writes == seen)
            @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic push_cmd(input logic [THR_W-1:0] a, input logic [THR_W-1:0] b,
                            input logic [THR_W-1:0] c, input logic [THR_W-1:0] d);
        cmds_to_send.push_back('{a, b, c, d});
        cmds_issued++;
    endtask

    // Wait until every command is taken and every slot of its frame has arrived
    task automatic drain();
        while (cmds_accepted != cmds_issued || slots_due.size() != 0)
            @(negedge clk);
    endtask

    // Bias towards the stop threshold and full throttle, rest uniform
    function automatic logic [THR_W-1:0] random_throttle();
        case ($urandom_range(0, 9))
            0: return THR_W'($urandom_range(0, 80));
            1: return THR_W'($urandom_range(65400, 65535));
            default: return THR_W'($urandom());
        endcase
    endfunction

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            push_cmd(random_throttle(), random_throttle(), random_throttle(),
                     random_throttle());
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.throttle_a = '0;
        cmd_bus.throttle_b = '0;
        cmd_bus.throttle_c = '0;
        cmd_bus.throttle_d = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = CFG_BIT_PERIOD;
        cfg_bus.data       = '0;
        slot_bus.ready     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings; back-to-back commands land while a frame is going out
        steady = 1'b1;
        push_cmd(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_cmd(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_cmd(16'd65, 16'd66, 16'd64, 16'd1);
        push_cmd(16'h8000, 16'h4000, 16'h0042, 16'hFFFE);
        push_cmd(16'hAAAA, 16'h5555, 16'h0100, 16'h7FFF);
        drain();
        steady = 1'b0;

        // Longest bit period, telemetry on
        write_reg(CFG_BIT_PERIOD, 16'hFFFF);
        write_reg(CFG_TELEMETRY, 16'h0001);
        push_cmd(16'hFFFF, 16'h0000, 16'd65, 16'd66);
        push_cmd(16'h1234, 16'hFEDC, 16'h0041, 16'h0043);
        drain();

        // Zero bit period gives all-zero compare values
        write_reg(CFG_BIT_PERIOD, 16'h0000);
        push_cmd(16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000);
        drain();

        // A very short bit period, and writes to undecoded indexes
        write_reg(CFG_BIT_PERIOD, 16'd9);
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h1234);
        write_reg(CFG_TELEMETRY, 16'hFFFE);
        push_cmd(16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC);
        drain();

        write_reg(CFG_BIT_PERIOD, 16'd10);
        push_cmd(16'h0001, 16'h7FFF, 16'hFFFF, 16'h0000);
        push_cmd(16'd100, 16'd1000, 16'd10000, 16'd60000);
        drain();

        // Random phases, each under a different setting
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(CFG_BIT_PERIOD, BIT_PERIOD_RESET);
                    write_reg(CFG_TELEMETRY, 16'h0000);
                end
                1:
                begin
                    write_reg(CFG_BIT_PERIOD, 16'hFFFF);
                    write_reg(CFG_TELEMETRY, 16'h0001);
                end
                2:
                begin
                    write_reg(CFG_BIT_PERIOD, 16'd10);
                    write_reg(CFG_TELEMETRY, 16'h0000);
                end
                3:
                begin
                    write_reg(CFG_BIT_PERIOD, CFG_DATA_W'($urandom_range(10, 65535)));
                    write_reg(CFG_TELEMETRY, CFG_DATA_W'($urandom()));
                end
                4:
                begin
                    write_reg(CFG_BIT_PERIOD, CFG_DATA_W'($urandom_range(0, 9)));
                    write_reg(CFG_TELEMETRY, 16'h0001);
                end
                default:
                begin
                    write_reg(CFG_BIT_PERIOD, CFG_DATA_W'($urandom()));
                    write_reg(CFG_TELEMETRY, CFG_DATA_W'($urandom()));
                end
            endcase
            case (p)
                0:
                begin
                    // no idling on either side for the whole phase
                    steady = 1'b1;
                    push_random(PHASE_ITEMS);
                    drain();
                    steady = 1'b0;
                end
                1:
                begin
                    // stall the receiver while commands keep coming
                    push_random(30);
                    hold_requests++;
                    push_random(PHASE_ITEMS - 30);
                    drain();
                end
                2:
                begin
                    // pause the sender until the frames so far are out
                    push_random(25);
                    drain();
                    push_random(PHASE_ITEMS - 25);
                    drain();
                end
                default:
                begin
                    push_random(PHASE_ITEMS);
                    drain();
                end
            endcase
        end

        repeat (FRAME_LEN + 10) @(negedge clk);
        if (slots_due.size() != 0)
            report_mismatch("slots never delivered", 32'(slots_due.size()), 32'd0);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
